// ===== sv/nrsa_pkg.sv =====
package nrsa_pkg;

   // frame geometry
   localparam int MAX_DIM    = 4096;
   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int FRAC_W     = 20;
   localparam int SCALE_FRAC = 10;
   localparam int SC_W       = DIM_W + SCALE_FRAC;
   localparam int LUMA_W     = 24;
   localparam int CHROMA_W   = 23;
   localparam int ROT_W      = 2;

   // control register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION      = 3'd4;

   // rotation codes
   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // settled geometry shared by front and back
   typedef struct packed {
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
      logic [DIM_W-1:0]   sw;
      logic [ROT_W-1:0]   rot;
      logic [DIM_W-1:0]   scw;
      logic [DIM_W-1:0]   sch;
      logic [COORD_W-1:0] stx;
      logic [COORD_W-1:0] sty;
      logic               area_ok;
      logic               ready;
   } geom_type;

   // one classified pixel on its way to the back end
   typedef struct packed {
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      logic               in_area;
      logic               chroma;
   } item_type;

endpackage

// ===== sv/nrsa_setup.sv =====
module nrsa_setup import nrsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output geom_type             geom
);

   localparam logic [2:0] ST_START = 3'd0;
   localparam logic [2:0] ST_DIV_X = 3'd1;
   localparam logic [2:0] ST_DIV_Y = 3'd2;
   localparam logic [2:0] ST_FIT   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam int CNT_W = $clog2(SC_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SC_W - 1);

   function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] raw);
      logic [DIM_W-1:0] v;
      v = (raw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : raw;
      return {v[DIM_W-1:1], 1'b0};
   endfunction

   logic [DIM_W-1:0] src_w_ff, src_h_ff, scr_w_ff, scr_h_ff;
   logic [ROT_W-1:0] rot_ff;
   logic [2:0]       state_ff, state_in;
   logic [SC_W-1:0]  num_ff, num_in;
   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [DIM_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SC_W-1:0]  scx_ff, scx_in, scy_ff, scy_in;
   logic [DIM_W-1:0] scw_ff, scw_in, sch_ff, sch_in;
   logic [COORD_W-1:0] stx_ff, stx_in, sty_ff, sty_in;
   logic             area_ok_ff, area_ok_in;

   logic [DIM_W-1:0] w, h, sw, sh, lw, lh;
   logic [DIM_W:0]   rem2, rem_sub;
   logic             ge;
   logic [SC_W-1:0]  sc, quot;
   logic [SC_W+DIM_W-1:0] prod_w, prod_h;
   logic [DIM_W-1:0] diff_x, diff_y;

   // effective sizes and the rotated source frame
   always_comb begin
      w  = eff_size(src_w_ff);
      h  = eff_size(src_h_ff);
      sw = eff_size(scr_w_ff);
      sh = eff_size(scr_h_ff);
      lw = rot_ff[0] ? h : w;
      lh = rot_ff[0] ? w : h;
   end

   // shared restoring divider step, quotient shifts into num
   always_comb begin
      rem2    = {rem_ff, num_ff[SC_W-1]};
      rem_sub = rem2 - {1'b0, div_ff};
      ge      = rem2 >= {1'b0, div_ff};
      quot    = {num_ff[SC_W-2:0], ge};
   end

   // fit sizes and centring
   always_comb begin
      sc     = (scx_ff < scy_ff) ? scx_ff : scy_ff;
      prod_w = sc * lw;
      prod_h = sc * lh;
      diff_x = sw - scw_ff;
      diff_y = sh - sch_ff;
   end

   // setup sequencer
   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      scx_in     = scx_ff;
      scy_in     = scy_ff;
      scw_in     = scw_ff;
      sch_in     = sch_ff;
      stx_in     = stx_ff;
      sty_in     = sty_ff;
      area_ok_in = area_ok_ff;
      unique case (state_ff)
         ST_START: begin
            area_ok_in = 1'b0;
            if (w == '0 || h == '0 || sw == '0 || sh == '0) begin
               state_in = ST_DONE;
            end else begin
               num_in   = {sw, {SCALE_FRAC{1'b0}}};
               div_in   = lw;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV_X;
            end
         end
         ST_DIV_X, ST_DIV_Y: begin
            rem_in = ge ? rem_sub[DIM_W-1:0] : rem2[DIM_W-1:0];
            num_in = quot;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in = '0;
               rem_in = '0;
               if (state_ff == ST_DIV_X) begin
                  scx_in   = quot;
                  num_in   = {sh, {SCALE_FRAC{1'b0}}};
                  div_in   = lh;
                  state_in = ST_DIV_Y;
               end else begin
                  scy_in   = quot;
                  state_in = ST_FIT;
               end
            end
         end
         ST_FIT: begin
            scw_in   = {prod_w[SC_W-1:SCALE_FRAC+1], 1'b0};
            sch_in   = {prod_h[SC_W-1:SCALE_FRAC+1], 1'b0};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            stx_in     = {diff_x[DIM_W-1:2], 1'b0};
            sty_in     = {diff_y[DIM_W-1:2], 1'b0};
            area_ok_in = (scw_ff != '0) && (sch_ff != '0);
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_START;
         end
      endcase
      if (csr_we) begin
         state_in = ST_START;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_W'(1280);
         src_h_ff <= DIM_W'(720);
         scr_w_ff <= DIM_W'(480);
         scr_h_ff <= DIM_W'(800);
         rot_ff   <= ROT_NONE;
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:     src_w_ff <= csr_wdata;
            REG_SRC_HEIGHT:    src_h_ff <= csr_wdata;
            REG_SCREEN_WIDTH:  scr_w_ff <= csr_wdata;
            REG_SCREEN_HEIGHT: scr_h_ff <= csr_wdata;
            REG_ROTATION:      rot_ff   <= csr_wdata[ROT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_START;
         area_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         area_ok_ff <= area_ok_in;
      end
   end

   // divider and geometry datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      scx_ff <= scx_in;
      scy_ff <= scy_in;
      scw_ff <= scw_in;
      sch_ff <= sch_in;
      stx_ff <= stx_in;
      sty_ff <= sty_in;
   end

   assign geom = '{w: w, h: h, sw: sw, rot: rot_ff, scw: scw_ff, sch: sch_ff,
                   stx: stx_ff, sty: sty_ff, area_ok: area_ok_ff,
                   ready: (state_ff == ST_DONE)};

endmodule

// ===== sv/nrsa_front.sv =====
module nrsa_front import nrsa_pkg::*; (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_scaled_col,
   input  logic [COORD_W-1:0] req_scaled_row,
   input  geom_type           geom,
   input  logic               queue_full,
   output logic               push,
   output item_type           item
);

   assign req_ready = geom.ready & ~queue_full;
   assign push      = req_valid & req_ready;

   // classify the pixel and place it on the screen
   always_comb begin
      item.dx      = req_scaled_col;
      item.dy      = req_scaled_row;
      item.ox      = geom.stx + req_scaled_col;
      item.oy      = geom.sty + req_scaled_row;
      item.in_area = geom.area_ok
                     && ({1'b0, req_scaled_col} < geom.scw)
                     && ({1'b0, req_scaled_row} < geom.sch);
      item.chroma  = item.in_area & ~req_scaled_col[0] & ~req_scaled_row[0];
   end

endmodule

// ===== sv/nrsa_queue.sv =====
module nrsa_queue import nrsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     empty
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue underflow");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue level out of range");

endmodule

// ===== sv/nrsa_back.sv =====
module nrsa_back import nrsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  geom_type            geom,
   input  logic                queue_empty,
   input  item_type            queue_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_in_area,
   output logic [COORD_W-1:0]  rsp_source_x,
   output logic [COORD_W-1:0]  rsp_source_y,
   output logic [COORD_W-1:0]  rsp_dest_x,
   output logic [COORD_W-1:0]  rsp_dest_y,
   output logic [LUMA_W-1:0]   rsp_luma_src_offset,
   output logic [LUMA_W-1:0]   rsp_luma_dst_offset,
   output logic                rsp_chroma_write,
   output logic [CHROMA_W-1:0] rsp_chroma_src_offset,
   output logic [CHROMA_W-1:0] rsp_chroma_dst_offset
);

   typedef struct packed {
      logic               valid;
      item_type           it;
      logic [DIM_W-1:0]   rem_u;
      logic [DIM_W-1:0]   rem_v;
      logic [FRAC_W-1:0]  q_u;
      logic [FRAC_W-1:0]  q_v;
   } div_stage_type;

   localparam int PROD_W = FRAC_W + DIM_W;

   logic          adv;
   div_stage_type div_ff [FRAC_W+1];
   div_stage_type div_in [FRAC_W+1];

   logic [PROD_W-1:0] p_uw, p_uh, p_vw, p_vh;
   logic              mul_valid_ff;
   item_type          mul_it_ff;
   logic [COORD_W-1:0] su_w_ff, su_h_ff, sv_w_ff, sv_h_ff;

   logic              xy_valid_ff;
   item_type          xy_it_ff;
   logic [COORD_W-1:0] x_ff, y_ff, x_in, y_in;

   logic              rsp_valid_ff;
   logic              in_area_ff, chroma_ff;
   logic [COORD_W-1:0] sx_ff, sy_ff, ox_ff, oy_ff;
   logic [LUMA_W-1:0]  luma_src_ff, luma_dst_ff;
   logic [CHROMA_W-1:0] chroma_src_ff, chroma_dst_ff;
   logic [DIM_W+COORD_W-1:0] m_ls, m_ld;
   logic [DIM_W+COORD_W-2:0] m_cs, m_cd;

   // whole pipeline moves unless the result register is held
   assign adv = ~(rsp_valid_ff & ~rsp_ready);
   assign pop = adv & ~queue_empty;

   // one quotient bit of dx/scw and dy/sch per stage
   always_comb begin
      logic [DIM_W:0] ru, rv;
      logic           gu, gv;
      div_in[0].valid = pop;
      div_in[0].it    = queue_item;
      div_in[0].rem_u = {1'b0, queue_item.dx};
      div_in[0].rem_v = {1'b0, queue_item.dy};
      div_in[0].q_u   = '0;
      div_in[0].q_v   = '0;
      for (int k = 1; k <= FRAC_W; k++) begin
         ru = {div_ff[k-1].rem_u, 1'b0};
         rv = {div_ff[k-1].rem_v, 1'b0};
         gu = ru >= {1'b0, geom.scw};
         gv = rv >= {1'b0, geom.sch};
         div_in[k].valid = div_ff[k-1].valid;
         div_in[k].it    = div_ff[k-1].it;
         div_in[k].rem_u = gu ? DIM_W'(ru - {1'b0, geom.scw}) : ru[DIM_W-1:0];
         div_in[k].rem_v = gv ? DIM_W'(rv - {1'b0, geom.sch}) : rv[DIM_W-1:0];
         div_in[k].q_u   = {div_ff[k-1].q_u[FRAC_W-2:0], gu};
         div_in[k].q_v   = {div_ff[k-1].q_v[FRAC_W-2:0], gv};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= FRAC_W; k++) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (adv) begin
            div_ff[k].valid <= div_in[k].valid;
         end
         if (adv) begin
            div_ff[k].it    <= div_in[k].it;
            div_ff[k].rem_u <= div_in[k].rem_u;
            div_ff[k].rem_v <= div_in[k].rem_v;
            div_ff[k].q_u   <= div_in[k].q_u;
            div_ff[k].q_v   <= div_in[k].q_v;
         end
      end
   end

   // scale the fractions back to source pixels
   always_comb begin
      p_uw = div_ff[FRAC_W].q_u * geom.w;
      p_uh = div_ff[FRAC_W].q_u * geom.h;
      p_vw = div_ff[FRAC_W].q_v * geom.w;
      p_vh = div_ff[FRAC_W].q_v * geom.h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= div_ff[FRAC_W].valid;
      end
      if (adv) begin
         mul_it_ff <= div_ff[FRAC_W].it;
         su_w_ff   <= p_uw[FRAC_W+COORD_W-1:FRAC_W];
         su_h_ff   <= p_uh[FRAC_W+COORD_W-1:FRAC_W];
         sv_w_ff   <= p_vw[FRAC_W+COORD_W-1:FRAC_W];
         sv_h_ff   <= p_vh[FRAC_W+COORD_W-1:FRAC_W];
      end
   end

   // rotation; results stay below the source size so no clamp is needed
   always_comb begin
      logic [DIM_W-1:0] wm1, hm1;
      wm1 = geom.w - 1'b1;
      hm1 = geom.h - 1'b1;
      unique case (geom.rot)
         ROT_90: begin
            x_in = sv_w_ff;
            y_in = COORD_W'(hm1 - {1'b0, su_h_ff});
         end
         ROT_180: begin
            x_in = COORD_W'(wm1 - {1'b0, su_w_ff});
            y_in = COORD_W'(hm1 - {1'b0, sv_h_ff});
         end
         ROT_270: begin
            x_in = COORD_W'(wm1 - {1'b0, sv_w_ff});
            y_in = su_h_ff;
         end
         default: begin
            x_in = su_w_ff;
            y_in = sv_h_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xy_valid_ff <= 1'b0;
      end else if (adv) begin
         xy_valid_ff <= mul_valid_ff;
      end
      if (adv) begin
         xy_it_ff <= mul_it_ff;
         x_ff     <= x_in;
         y_ff     <= y_in;
      end
   end

   // plane offsets
   always_comb begin
      m_ls = y_ff * geom.w;
      m_ld = xy_it_ff.oy * geom.sw;
      m_cs = y_ff[COORD_W-1:1] * geom.w;
      m_cd = xy_it_ff.oy[COORD_W-1:1] * geom.sw;
   end

   // result register, fields cleared outside the area
   always_ff @(posedge clock) begin
      logic ia, cw;
      ia = xy_it_ff.in_area;
      cw = xy_it_ff.chroma;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= xy_valid_ff;
      end
      if (adv) begin
         in_area_ff    <= ia;
         chroma_ff     <= cw;
         sx_ff         <= ia ? x_ff : '0;
         sy_ff         <= ia ? y_ff : '0;
         ox_ff         <= ia ? xy_it_ff.ox : '0;
         oy_ff         <= ia ? xy_it_ff.oy : '0;
         luma_src_ff   <= ia ? LUMA_W'(m_ls + x_ff) : '0;
         luma_dst_ff   <= ia ? LUMA_W'(m_ld + xy_it_ff.ox) : '0;
         chroma_src_ff <= cw ? CHROMA_W'(m_cs + {x_ff[COORD_W-1:1], 1'b0}) : '0;
         chroma_dst_ff <= cw ? CHROMA_W'(m_cd + {xy_it_ff.ox[COORD_W-1:1], 1'b0}) : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_in_area           = in_area_ff;
   assign rsp_source_x          = sx_ff;
   assign rsp_source_y          = sy_ff;
   assign rsp_dest_x            = ox_ff;
   assign rsp_dest_y            = oy_ff;
   assign rsp_luma_src_offset   = luma_src_ff;
   assign rsp_luma_dst_offset   = luma_dst_ff;
   assign rsp_chroma_write      = chroma_ff;
   assign rsp_chroma_src_offset = chroma_src_ff;
   assign rsp_chroma_dst_offset = chroma_dst_ff;

endmodule

// ===== sv/nv12_rotate_scale_address_gen.sv =====
// Address generator for a nearest-neighbour NV12 rotate and letterbox scale.
// Control port: csr_we writes csr_wdata into register csr_index (source width,
// source height, screen width, screen height, rotation); no read-back.
// After reset and after every control write a setup sequencer works out the
// Q10 fit scale, scaled size and centring with the shared one-bit-per-cycle
// divider, run twice. req_ready stays low until the sequencer is done.
// Request channel: one beat carries a scaled-area column and row.
// Response channel: one beat per request, in order, with source and screen
// coordinates, Y and UV plane byte offsets and the chroma write flag.
// Throughput is one beat per cycle while the receiver takes responses and
// setup is done. A request beat passes through the queue, the pipelined
// divider for the Q20 fractions and the multiply, rotate and offset stages.
// When the receiver stalls the response register holds and the back end
// freezes; the front keeps taking beats until the 4-entry queue fills, then
// drops req_ready. Reset is synchronous and clears all valid state and the
// control registers to their defaults.
module nv12_rotate_scale_address_gen import nrsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COORD_W-1:0]   req_scaled_col,
   input  logic [COORD_W-1:0]   req_scaled_row,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_in_area,
   output logic [COORD_W-1:0]   rsp_source_x,
   output logic [COORD_W-1:0]   rsp_source_y,
   output logic [COORD_W-1:0]   rsp_dest_x,
   output logic [COORD_W-1:0]   rsp_dest_y,
   output logic [LUMA_W-1:0]    rsp_luma_src_offset,
   output logic [LUMA_W-1:0]    rsp_luma_dst_offset,
   output logic                 rsp_chroma_write,
   output logic [CHROMA_W-1:0]  rsp_chroma_src_offset,
   output logic [CHROMA_W-1:0]  rsp_chroma_dst_offset
);

   geom_type geom;
   item_type push_item, pop_item;
   logic     push, pop, q_full, q_empty;

   nrsa_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   nrsa_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_scaled_col (req_scaled_col),
      .req_scaled_row (req_scaled_row),
      .geom           (geom),
      .queue_full     (q_full),
      .push           (push),
      .item           (push_item)
   );

   nrsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   nrsa_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .geom                  (geom),
      .queue_empty           (q_empty),
      .queue_item            (pop_item),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_in_area           (rsp_in_area),
      .rsp_source_x          (rsp_source_x),
      .rsp_source_y          (rsp_source_y),
      .rsp_dest_x            (rsp_dest_x),
      .rsp_dest_y            (rsp_dest_y),
      .rsp_luma_src_offset   (rsp_luma_src_offset),
      .rsp_luma_dst_offset   (rsp_luma_dst_offset),
      .rsp_chroma_write      (rsp_chroma_write),
      .rsp_chroma_src_offset (rsp_chroma_src_offset),
      .rsp_chroma_dst_offset (rsp_chroma_dst_offset)
   );

endmodule

// ===== tb/sv/nv12_rotate_scale_address_gen_tb.sv =====
`timescale 1ns / 1ps

module nv12_rotate_scale_address_gen_tb;
   import nrsa_pkg::*;

   // one response beat as the block should produce it
   typedef struct {
      logic                in_area;
      logic [COORD_W-1:0]  source_x;
      logic [COORD_W-1:0]  source_y;
      logic [COORD_W-1:0]  dest_x;
      logic [COORD_W-1:0]  dest_y;
      logic [LUMA_W-1:0]   luma_src;
      logic [LUMA_W-1:0]   luma_dst;
      logic                chroma_write;
      logic [CHROMA_W-1:0] chroma_src;
      logic [CHROMA_W-1:0] chroma_dst;
   } pixel_addr_type;

   // address predictor plus the queue of pixel addresses still to come
   class addr_scoreboard;
      logic [DIM_W-1:0] src_w, src_h, scr_w, scr_h;
      logic [ROT_W-1:0] rot;
      pixel_addr_type   pending_addrs[$];
      int               errors;
      int               in_area_seen;
      int               chroma_seen;

      function new();
         src_w = 1280; src_h = 720; scr_w = 480; scr_h = 800; rot = ROT_NONE;
         errors = 0; in_area_seen = 0; chroma_seen = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
         case (idx)
            REG_SRC_WIDTH:     src_w = val;
            REG_SRC_HEIGHT:    src_h = val;
            REG_SCREEN_WIDTH:  scr_w = val;
            REG_SCREEN_HEIGHT: scr_h = val;
            REG_ROTATION:      rot = val[ROT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned even_dim(logic [DIM_W-1:0] raw);
         longint unsigned v;
         v = 64'(raw);
         if (v > MAX_DIM) v = MAX_DIM;
         return v & ~64'd1;
      endfunction

      // fit scale, scaled size and centring start
      function void fit(output longint unsigned scw, sch, stx, sty);
         longint unsigned w, h, sw, sh, lw, lh, scx, scy, sc;
         w = even_dim(src_w); h = even_dim(src_h);
         sw = even_dim(scr_w); sh = even_dim(scr_h);
         scw = 0; sch = 0; stx = 0; sty = 0;
         if (w == 0 || h == 0 || sw == 0 || sh == 0) return;
         lw = rot[0] ? h : w;
         lh = rot[0] ? w : h;
         scx = sw * 1024 / lw;
         scy = sh * 1024 / lh;
         sc = (scx < scy) ? scx : scy;
         scw = ((sc * lw) / 1024) & ~64'd1;
         sch = ((sc * lh) / 1024) & ~64'd1;
         stx = ((sw - scw) / 2) & ~64'd1;
         sty = ((sh - sch) / 2) & ~64'd1;
      endfunction

      function longint unsigned clamp(longint c, longint unsigned lim);
         if (c < 0) return 0;
         if (longint'(c) >= longint'(lim)) return lim - 1;
         return c;
      endfunction

      // note an accepted request beat
      function void note_request(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         pixel_addr_type  e;
         longint unsigned scw, sch, stx, sty, w, h, sw, u, v, x, y, ox, oy;
         longint          xs, ys;
         e = '{default: '0};
         fit(scw, sch, stx, sty);
         if (scw != 0 && sch != 0 && col < scw && row < sch) begin
            w = even_dim(src_w); h = even_dim(src_h); sw = even_dim(scr_w);
            u = (longint'(col) << 20) / scw;
            v = (longint'(row) << 20) / sch;
            case (rot)
               ROT_90: begin
                  xs = (v * w) >> 20;
                  ys = longint'(h) - 1 - longint'((u * h) >> 20);
               end
               ROT_180: begin
                  xs = longint'(w) - 1 - longint'((u * w) >> 20);
                  ys = longint'(h) - 1 - longint'((v * h) >> 20);
               end
               ROT_270: begin
                  xs = longint'(w) - 1 - longint'((v * w) >> 20);
                  ys = (u * h) >> 20;
               end
               default: begin
                  xs = (u * w) >> 20;
                  ys = (v * h) >> 20;
               end
            endcase
            x = clamp(xs, w);
            y = clamp(ys, h);
            ox = stx + col;
            oy = sty + row;
            e.in_area  = 1'b1;
            e.source_x = COORD_W'(x);
            e.source_y = COORD_W'(y);
            e.dest_x   = COORD_W'(ox);
            e.dest_y   = COORD_W'(oy);
            e.luma_src = LUMA_W'(y * w + x);
            e.luma_dst = LUMA_W'(oy * sw + ox);
            if (!col[0] && !row[0]) begin
               e.chroma_write = 1'b1;
               e.chroma_src   = CHROMA_W'((y / 2) * w + 2 * (x / 2));
               e.chroma_dst   = CHROMA_W'((oy / 2) * sw + (ox & ~64'd1));
            end
         end
         pending_addrs.push_back(e);
      endfunction

      function void field(string name, longint unsigned exp, longint unsigned act);
         if (exp != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
         end
      endfunction

      // compare a response beat with the oldest prediction
      function void check_response(pixel_addr_type a);
         pixel_addr_type e;
         if (pending_addrs.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat, expected none, actual in_area %0d",
                     $time, a.in_area);
            return;
         end
         e = pending_addrs.pop_front();
         if (e.in_area) in_area_seen++;
         if (e.chroma_write) chroma_seen++;
         field("in_area", e.in_area, a.in_area);
         field("source_x", e.source_x, a.source_x);
         field("source_y", e.source_y, a.source_y);
         field("dest_x", e.dest_x, a.dest_x);
         field("dest_y", e.dest_y, a.dest_y);
         field("luma_src_offset", e.luma_src, a.luma_src);
         field("luma_dst_offset", e.luma_dst, a.luma_dst);
         field("chroma_write", e.chroma_write, a.chroma_write);
         field("chroma_src_offset", e.chroma_src, a.chroma_src);
         field("chroma_dst_offset", e.chroma_dst, a.chroma_dst);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [COORD_W-1:0]   req_scaled_col = '0;
   logic [COORD_W-1:0]   req_scaled_row = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_in_area;
   logic [COORD_W-1:0]   rsp_source_x, rsp_source_y, rsp_dest_x, rsp_dest_y;
   logic [LUMA_W-1:0]    rsp_luma_src_offset, rsp_luma_dst_offset;
   logic                 rsp_chroma_write;
   logic [CHROMA_W-1:0]  rsp_chroma_src_offset, rsp_chroma_dst_offset;

   addr_scoreboard sb = new();
   int  req_gap_max = 15;
   int  rsp_gap_max = 15;
   bit  long_hold = 1'b0;
   int  cycles = 0;
   int  beats_sent = 0;
   int  phases_run = 0;

   nv12_rotate_scale_address_gen uut (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("nv12_rotate_scale_address_gen_tb NOT OK");
         $finish;
      end
   end

   // response side: random stalls, one long hold when asked
   initial begin : rsp_side
      int             stall;
      pixel_addr_type a;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            stall = 300;
            long_hold = 1'b0;
         end else begin
            stall = $urandom_range(0, rsp_gap_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         a.in_area      = rsp_in_area;
         a.source_x     = rsp_source_x;
         a.source_y     = rsp_source_y;
         a.dest_x       = rsp_dest_x;
         a.dest_y       = rsp_dest_y;
         a.luma_src     = rsp_luma_src_offset;
         a.luma_dst     = rsp_luma_dst_offset;
         a.chroma_write = rsp_chroma_write;
         a.chroma_src   = rsp_chroma_src_offset;
         a.chroma_dst   = rsp_chroma_dst_offset;
         sb.check_response(a);
      end
   end

   // one register write; the caller drops csr_we after the last one
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // offer one request beat and wait for its acceptance
   task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_scaled_col <= col;
      req_scaled_row <= row;
      do @(posedge clock); while (!req_ready);
      sb.note_request(col, row);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_addrs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // directed corners of the scaled area, then mostly in-area random pixels
   task automatic run_phase(int n_random, int pause_at);
      longint unsigned scw, sch, stx, sty;
      logic [COORD_W-1:0] c, r;
      sb.fit(scw, sch, stx, sty);
      send_pixel(0, 0);
      send_pixel(COORD_W'(scw - 1), COORD_W'(sch - 1));
      send_pixel(COORD_W'(scw), 0);
      send_pixel(0, COORD_W'(sch));
      send_pixel(COORD_W'(scw - 1), 0);
      send_pixel(0, COORD_W'(sch - 1));
      send_pixel(1, 0);
      send_pixel(0, 1);
      send_pixel(COORD_W'(scw - 2), COORD_W'(sch - 2));
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      for (int i = 0; i < n_random; i++) begin
         if (i == pause_at) begin
            req_valid <= 1'b0;
            while (sb.pending_addrs.size() != 0) @(posedge clock);
         end
         if (scw != 0 && sch != 0 && $urandom_range(0, 99) < 85) begin
            c = COORD_W'($urandom_range(0, 32'(scw - 1)));
            r = COORD_W'($urandom_range(0, 32'(sch - 1)));
         end else begin
            c = COORD_W'($urandom_range(0, 4095));
            r = COORD_W'($urandom_range(0, 4095));
         end
         send_pixel(c, r);
      end
      drain();
      phases_run++;
   endtask

   task automatic configure(int w, int h, int sw, int sh, int rt);
      write_reg(REG_SRC_WIDTH, DIM_W'(w));
      write_reg(REG_SRC_HEIGHT, DIM_W'(h));
      write_reg(REG_SCREEN_WIDTH, DIM_W'(sw));
      write_reg(REG_SCREEN_HEIGHT, DIM_W'(sh));
      write_reg(REG_ROTATION, DIM_W'(rt));
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults
      run_phase(80, -1);

      // all rotations of the default geometry; the 90 phase has a long response hold
      for (int rt = 0; rt < 4; rt++) begin
         configure(1280, 720, 480, 800, rt);
         if (rt == ROT_90) begin
            req_gap_max = 0;
            long_hold = 1'b1;
         end
         run_phase(95, (rt == ROT_180) ? 55 : -1);
         req_gap_max = 15;
      end

      // extremes: largest, saturated, smallest, odd and zero sizes
      configure(4096, 4096, 4096, 4096, ROT_NONE);
      run_phase(110, -1);
      configure(8191, 8191, 2, 2, ROT_90);
      run_phase(60, -1);
      configure(2, 2, 4096, 4096, ROT_180);
      run_phase(110, -1);
      configure(0, 720, 480, 800, ROT_NONE);
      run_phase(40, -1);
      configure(1280, 1, 480, 800, ROT_270);
      run_phase(40, -1);
      configure(4095, 3, 4097, 17, ROT_270);
      run_phase(80, -1);
      configure(640, 480, 1, 0, ROT_90);
      run_phase(30, -1);

      // random geometry, some phases without any idling
      for (int p = 0; p < 6; p++) begin
         req_gap_max = (p % 3 == 0) ? 0 : 15;
         rsp_gap_max = (p % 3 == 1) ? 0 : 15;
         configure($urandom_range(2, 4096), $urandom_range(2, 4096),
                   $urandom_range(2, 4096), $urandom_range(2, 4096),
                   $urandom_range(0, 3));
         run_phase(90, -1);
      end

      $display("covered %0d phases, %0d request beats, %0d in area, %0d chroma writes",
               phases_run, beats_sent, sb.in_area_seen, sb.chroma_seen);
      $display("all rotations, saturated, odd, zero and minimum sizes, stalls and long hold");
      if (sb.errors == 0 && sb.pending_addrs.size() == 0) begin
         $display("nv12_rotate_scale_address_gen_tb OK");
      end else begin
         $display("nv12_rotate_scale_address_gen_tb NOT OK");
      end
      $finish;
   end

endmodule
